// ===== rtl/sfg_pkg.sv =====
// ----------------------------------------------------------------------------
// Slew function generator package
// Shared constants, types and the exponential coefficients.
// ----------------------------------------------------------------------------
package sfg_pkg;

   localparam int LEVEL_FRAC_BITS = 27;
   localparam int Q11_SHIFT = LEVEL_FRAC_BITS - 11;
   localparam int ACC_W = LEVEL_FRAC_BITS + 6;
   localparam int SUM_W = ACC_W + 2;
   localparam int L11_W = ACC_W - Q11_SHIFT;
   localparam int Q_W = LEVEL_FRAC_BITS + 6;
   localparam int T_W = 42;
   localparam int A_W = 58;
   localparam int NUM_W = A_W + LEVEL_FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam logic [Q_W-1:0] STEP_CAP = Q_W'(1) << (LEVEL_FRAC_BITS + 5);
   localparam logic signed [ACC_W-1:0] LEVEL_16V = ACC_W'(16) << LEVEL_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] LEVEL_8V = ACC_W'(8) << LEVEL_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] LEVEL_5V = ACC_W'(5) << LEVEL_FRAC_BITS;

   localparam logic [31:0] SAMPLE_PERIOD_RESET = 32'd89478;
   localparam logic [31:0] EXP_SEED = 32'd1431680;
   localparam logic [31:0] EXP_ONE = 32'd1073741824;
   localparam logic [24:0] PITCH_C4 = 25'd17145895;

   typedef enum logic [2:0] {
      REG_RISE_KNOB   = 3'd0,
      REG_FALL_KNOB   = 3'd1,
      REG_RISE_DEPTH  = 3'd2,
      REG_FALL_DEPTH  = 3'd3,
      REG_RISE_SELF   = 3'd4,
      REG_FALL_SELF   = 3'd5,
      REG_CYCLE       = 3'd6,
      REG_PERIOD      = 3'd7
   } sfg_reg_type;

   typedef enum logic [1:0] {
      STAGE_IDLE = 2'd0,
      STAGE_RISE = 2'd1,
      STAGE_FALL = 2'd2,
      STAGE_DONE = 2'd3
   } sfg_stage_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_UVAL,
      S_POLY,
      S_PM,
      S_NUM,
      S_SHIFT,
      S_DIV,
      S_APPLY
   } sfg_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sfg_div_status_type;

   function automatic logic [31:0] exp_coef(input logic [1:0] idx);
      logic [31:0] c;
      case (idx)
         2'd0:    c = 32'd10327388;
         2'd1:    c = 32'd59597083;
         2'd2:    c = 32'd257941248;
         default: c = 32'd744261118;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/sfg_serial_div.sv =====
// ----------------------------------------------------------------------------
// Slew function generator serial divider
// Restoring long division, one quotient bit per cycle, saturating at the cap.
// ----------------------------------------------------------------------------
module sfg_serial_div import sfg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     numerator,
   input  logic [T_W-1:0]       divisor,
   output sfg_div_status_type   status,
   output logic [Q_W-1:0]       quotient
);

   logic [NUM_W-1:0]     num_ff;
   logic [T_W-1:0]       div_ff;
   logic [T_W-1:0]       rem_ff, rem_in;
   logic [Q_W-1:0]       quo_ff;
   logic                 ovf_ff, dzero_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [T_W:0]         trial, diff;
   logic                 fits;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff = trial - {1'b0, div_ff};
   assign fits = trial >= {1'b0, div_ff};
   assign rem_in = fits ? diff[T_W-1:0] : trial[T_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numerator;
         div_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
         ovf_ff <= 1'b0;
         dzero_ff <= divisor == '0;
         cnt_ff <= DIV_CNT_W'(NUM_W);
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[Q_W-2:0], fits};
         ovf_ff <= ovf_ff | quo_ff[Q_W-1];
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = (ovf_ff || dzero_ff || quo_ff > STEP_CAP) ? STEP_CAP : quo_ff;

endmodule

// ===== rtl/slew_function_generator_core.sv =====
// ----------------------------------------------------------------------------
// Slew function generator core
// One channel of a rise/fall slew generator, one item per audio sample.
// ----------------------------------------------------------------------------
// An accepted item passes preparation and slope evaluation, then goes straight
// to the apply state when no slope moves the level or the slope time is zero;
// otherwise it also passes the exponential, pitch factor and 85-step serial
// division of the step size. One item at a time; a stalled result holds it.
// Reset clears the level to 0 V, the stage to idle, the trigger to low and the
// registers to their reset values at the next rising clock edge.
module slew_function_generator_core import sfg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // signal_level, trigger_level, pitch_level, rise_cv_level, fall_cv_level,
   // both_cv_level
   input  logic [95:0] req_tdata,
   // signal_present, trigger_present, pitch_present
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // level_out, end_flag, gate_out, bipolar_out, zero fill
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [12:0]        rise_knob_ff, fall_knob_ff;
   logic signed [13:0] rise_depth_ff, fall_depth_ff;
   logic               rise_self_ff, fall_self_ff, cycle_ff;
   logic [31:0]        period_ff;

   logic signed [15:0] sig_ff, trig_ff, rcv_ff, fcv_ff, bcv_ff;
   logic [15:0]        pitch_ff;
   logic               sig_on_ff, trig_on_ff, pitch_on_ff;

   logic signed [ACC_W-1:0] level_ff;
   sfg_stage_type      stage_ff;
   logic               trig_high_ff;

   sfg_state_type      state_ff, state_in;
   logic signed [30:0] prod_r_ff, prod_f_ff;
   logic               rise_sel_ff, fall_sel_ff, uzero_ff;
   logic [18:0]        au_ff;
   logic [31:0]        poly_ff;
   logic [2:0]         pcnt_ff;
   logic [25:0]        pm_ff;
   logic [20:0]        u2_ff;
   logic [A_W-1:0]     a_ff;
   logic [T_W-1:0]     t_ff;
   logic               rsp_valid_ff;
   logic [39:0]        rsp_data_ff;

   logic               csr_write, div_start, apply_go;
   sfg_div_status_type div_status;
   logic [Q_W-1:0]     step;

   logic signed [19:0] ur, uf, u_sel;
   logic               rise_go, fall_go;

   function automatic logic signed [16:0] clamp_cv(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
      logic signed [16:0] s;
      s = 17'(a) + 17'(b);
      if (s > 17'sd20480) begin
         s = 17'sd20480;
      end else if (s < -17'sd20480) begin
         s = -17'sd20480;
      end
      return s;
   endfunction

   function automatic logic signed [19:0] slope_u(input logic [12:0] knob,
                                                  input logic signed [30:0] prod);
      logic [30:0] mag;
      logic [46:0] scaled;
      logic [17:0] quo;
      mag = prod[30] ? 31'(-prod) : 31'(prod);
      scaled = 47'(mag[30:8]) * 47'(24'd13421773);
      quo = scaled[43:26];
      return $signed({3'b0, knob, 4'b0}) +
             (prod[30] ? -$signed({2'b0, quo}) : $signed({2'b0, quo}));
   endfunction

   function automatic logic [15:0] sat16(input logic signed [17:0] v);
      logic [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_knob_ff <= '0;
         fall_knob_ff <= '0;
         rise_depth_ff <= '0;
         fall_depth_ff <= '0;
         rise_self_ff <= 1'b0;
         fall_self_ff <= 1'b0;
         cycle_ff <= 1'b0;
         period_ff <= SAMPLE_PERIOD_RESET;
      end else if (csr_write) begin
         unique case (sfg_reg_type'(csr_paddr[4:2]))
            REG_RISE_KNOB:  rise_knob_ff <= csr_pwdata[12:0];
            REG_FALL_KNOB:  fall_knob_ff <= csr_pwdata[12:0];
            REG_RISE_DEPTH: rise_depth_ff <= $signed(csr_pwdata[13:0]);
            REG_FALL_DEPTH: fall_depth_ff <= $signed(csr_pwdata[13:0]);
            REG_RISE_SELF:  rise_self_ff <= csr_pwdata[0];
            REG_FALL_SELF:  fall_self_ff <= csr_pwdata[0];
            REG_CYCLE:      cycle_ff <= csr_pwdata[0];
            REG_PERIOD:     period_ff <= csr_pwdata;
            default:        period_ff <= period_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sfg_reg_type'(csr_paddr[4:2]))
         REG_RISE_KNOB:  csr_prdata = {19'b0, rise_knob_ff};
         REG_FALL_KNOB:  csr_prdata = {19'b0, fall_knob_ff};
         REG_RISE_DEPTH: csr_prdata = {18'b0, rise_depth_ff};
         REG_FALL_DEPTH: csr_prdata = {18'b0, fall_depth_ff};
         REG_RISE_SELF:  csr_prdata = {31'b0, rise_self_ff};
         REG_FALL_SELF:  csr_prdata = {31'b0, fall_self_ff};
         REG_CYCLE:      csr_prdata = {31'b0, cycle_ff};
         REG_PERIOD:     csr_prdata = period_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      div_start = 1'b0;
      apply_go = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = S_PREP;
            end
         end
         S_PREP: state_in = S_UVAL;
         S_UVAL: begin
            if ((rise_go || fall_go) && u_sel != '0) begin
               state_in = S_POLY;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_POLY: begin
            if (pcnt_ff == 3'd4) begin
               state_in = S_PM;
            end
         end
         S_PM:    state_in = S_NUM;
         S_NUM:   state_in = S_SHIFT;
         S_SHIFT: begin
            div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               apply_go = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Preparation terms
   logic signed [L11_W-1:0] lvl11;
   logic signed [16:0]      xr, xf;
   logic signed [ACC_W-1:0] sig_acc;
   logic                    trig_high_in, trig_edge;

   assign lvl11 = $signed(level_ff[ACC_W-1:Q11_SHIFT]);
   assign xr = rise_self_ff ? 17'(lvl11) : clamp_cv(rcv_ff, bcv_ff);
   assign xf = fall_self_ff ? 17'(lvl11) : clamp_cv(fcv_ff, bcv_ff);
   assign sig_acc = ACC_W'(sig_ff) <<< Q11_SHIFT;

   always_comb begin
      trig_high_in = trig_high_ff;
      trig_edge = 1'b0;
      if (trig_on_ff) begin
         if (trig_high_ff) begin
            if (trig_ff <= 16'sd0) begin
               trig_high_in = 1'b0;
            end
         end else if (trig_ff >= 16'sd2048) begin
            trig_high_in = 1'b1;
            trig_edge = 1'b1;
         end
      end
   end

   assign ur = slope_u(rise_knob_ff, prod_r_ff);
   assign uf = slope_u(fall_knob_ff, prod_f_ff);
   assign rise_go = (sig_on_ff && sig_acc > level_ff) || stage_ff == STAGE_RISE;
   assign fall_go = !rise_go &&
                    ((sig_on_ff && sig_acc < level_ff) || stage_ff == STAGE_FALL);
   assign u_sel = rise_go ? ur : uf;

   // Exponential, pitch factor and divider operands
   logic [29:0]     frac30;
   logic [61:0]     poly_prod;
   logic [56:0]     pm_prod;
   logic [4:0]      octave;
   logic signed [6:0] shamt;
   logic [6:0]      shl, shr;
   logic [NUM_W-1:0] numerator;

   assign frac30 = {pitch_ff[10:0], 19'b0};
   assign poly_prod = 62'(poly_ff) * 62'(frac30);
   assign pm_prod = 57'(PITCH_C4) * 57'(poly_ff);
   assign octave = {~pitch_ff[15], pitch_ff[14:11]};
   assign shamt = pitch_on_ff ? 7'($signed({2'b0, octave}) - 7'sd32 + 7'(LEVEL_FRAC_BITS))
                              : 7'(LEVEL_FRAC_BITS);
   assign shl = shamt[6] ? 7'd0 : 7'(shamt);
   assign shr = shamt[6] ? 7'(-shamt) : 7'd0;
   assign numerator = (NUM_W'(a_ff) << shl) >> shr;

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         sig_ff <= req_tuser[0] ? $signed(req_tdata[15:0]) : 16'sd0;
         trig_ff <= $signed(req_tdata[31:16]);
         pitch_ff <= req_tdata[47:32];
         rcv_ff <= $signed(req_tdata[63:48]);
         fcv_ff <= $signed(req_tdata[79:64]);
         bcv_ff <= $signed(req_tdata[95:80]);
         sig_on_ff <= req_tuser[0];
         trig_on_ff <= req_tuser[1];
         pitch_on_ff <= req_tuser[2];
      end
      if (state_ff == S_PREP) begin
         prod_r_ff <= 31'(rise_depth_ff) * 31'(xr);
         prod_f_ff <= 31'(fall_depth_ff) * 31'(xf);
      end
      if (state_ff == S_UVAL) begin
         rise_sel_ff <= rise_go;
         fall_sel_ff <= fall_go;
         uzero_ff <= u_sel == '0;
         au_ff <= u_sel[19] ? 19'(-u_sel) : 19'(u_sel);
         poly_ff <= EXP_SEED;
         pcnt_ff <= '0;
      end
      if (state_ff == S_POLY) begin
         pcnt_ff <= pcnt_ff + 3'd1;
         if (pcnt_ff == 3'd4) begin
            poly_ff <= EXP_ONE + poly_prod[61:30];
         end else begin
            poly_ff <= exp_coef(pcnt_ff[1:0]) + poly_prod[61:30];
         end
      end
      if (state_ff == S_PM) begin
         pm_ff <= pm_prod[55:30];
         u2_ff <= 21'((38'(au_ff) * 38'(au_ff)) >> 16);
      end
      if (state_ff == S_NUM) begin
         a_ff <= pitch_on_ff ? A_W'(A_W'(period_ff) * A_W'(pm_ff)) : A_W'(period_ff);
         t_ff <= T_W'(u2_ff) * T_W'(u2_ff);
      end
   end

   sfg_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (numerator),
      .divisor   (t_ff),
      .status    (div_status),
      .quotient  (step)
   );

   // Level update
   logic signed [ACC_W-1:0] lv;
   logic signed [SUM_W-1:0] sum;
   sfg_stage_type           st;
   logic                    end_bit;
   logic signed [L11_W-1:0] q11;
   logic [15:0]             level_out, bipolar_out;

   always_comb begin
      lv = level_ff;
      st = stage_ff;
      end_bit = 1'b1;
      sum = '0;
      if (rise_sel_ff) begin
         if (uzero_ff) begin
            lv = sig_acc;
            st = STAGE_FALL;
         end else begin
            sum = SUM_W'(level_ff) + $signed({2'b0, step});
            if (sum > SUM_W'(LEVEL_16V)) begin
               sum = SUM_W'(LEVEL_16V);
            end
            lv = ACC_W'(sum);
            end_bit = 1'b0;
         end
         if (sig_on_ff && lv >= sig_acc) begin
            lv = sig_acc;
         end
         if (st == STAGE_RISE && lv >= LEVEL_8V) begin
            st = STAGE_FALL;
            lv = LEVEL_8V;
         end
      end else if (fall_sel_ff) begin
         if (uzero_ff) begin
            lv = sig_acc;
            st = STAGE_DONE;
         end else begin
            sum = SUM_W'(level_ff) - $signed({2'b0, step});
            if (sum < -SUM_W'(LEVEL_16V)) begin
               sum = -SUM_W'(LEVEL_16V);
            end
            lv = ACC_W'(sum);
            end_bit = 1'b0;
         end
         if (sig_on_ff && lv <= sig_acc) begin
            lv = sig_acc;
         end
         if (st == STAGE_FALL && lv <= ACC_W'(0)) begin
            st = STAGE_DONE;
            lv = '0;
         end
      end
   end

   assign q11 = $signed(lv[ACC_W-1:Q11_SHIFT]);
   assign level_out = sat16(18'(q11));
   assign bipolar_out = sat16(18'(q11) - 18'sd10240);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         stage_ff <= STAGE_IDLE;
         trig_high_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_PREP) begin
            trig_high_ff <= trig_high_in;
            if ((trig_edge || cycle_ff) &&
                (stage_ff == STAGE_IDLE || stage_ff == STAGE_DONE)) begin
               stage_ff <= STAGE_RISE;
            end
         end
         if (apply_go) begin
            level_ff <= lv;
            stage_ff <= st;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (apply_go) begin
         rsp_data_ff <= {6'b0, bipolar_out, lv > LEVEL_5V, end_bit, level_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== rtl/sfg_checker.sv =====
// ----------------------------------------------------------------------------
// Slew function generator port checker
// Checks the result channel and the output fields against each other.
// ----------------------------------------------------------------------------
module sfg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        csr_pready
);

   logic signed [17:0] level_v, bipolar_v, expect_bip;

   assign level_v = 18'($signed(rsp_tdata[15:0]));
   assign bipolar_v = 18'($signed(rsp_tdata[33:18]));
   assign expect_bip = (level_v - 18'sd10240 < -18'sd32768) ? -18'sd32768
                                                            : level_v - 18'sd10240;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_gate_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> level_v >= 18'sd10240)
      else $error("gate high with level at or below 5 V");

   // A saturated level hides whether the level sits at or just above full scale.
   a_bipolar: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && level_v != 18'sd32767 |-> bipolar_v == expect_bip)
      else $error("bipolar output does not match level");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind slew_function_generator_core sfg_checker u_sfg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slew function generator core testbench
// Drives audio-sample items through the request stream, predicts every result
// with an independent model of the slew, ramp and trigger logic, and checks
// each result field by field under random idling and several register setups.
// ----------------------------------------------------------------------------
module tb_top;
   import sfg_pkg::*;

   typedef struct packed {
      logic [5:0]         zero_fill;
      logic signed [15:0] bipolar;
      logic               gate;
      logic               end_flag;
      logic signed [15:0] level;
   } slew_result_type;

   typedef struct {
      logic [95:0] data;
      logic [2:0]  user;
   } sample_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sample_item_type sample_q[$];
   slew_result_type result_q[$];
   longint unsigned reg_shadow[8];
   longint         level_acc;
   sfg_stage_type  stage;
   bit             trig_high;
   int n_sent = 0;
   int n_taken = 0;
   int errors = 0;
   int quiet_cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;

   slew_function_generator_core dut (.*);

   always #1 clock = ~clock;

   function automatic longint sext_bits(longint unsigned v, int w);
      longint m;
      m = longint'(1) << (w - 1);
      v = v & ((m << 1) - 1);
      return longint'(v ^ m) - m;
   endfunction

   function automatic longint acc_to_volts(longint a);
      if (a >= 0) return a >>> 16;
      return -((-a + 65535) >>> 16);
   endfunction

   function automatic longint sat16(longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   function automatic longint unsigned exp2_frac(logic [10:0] f11);
      longint unsigned f, a;
      f = longint'(f11) << 19;
      a = 1431680;
      a = 10327388 + ((a * f) >> 30);
      a = 59597083 + ((a * f) >> 30);
      a = 257941248 + ((a * f) >> 30);
      a = 744261118 + ((a * f) >> 30);
      return (64'd1 << 30) + ((a * f) >> 30);
   endfunction

   function automatic longint unsigned step_divide(longint unsigned a, int s,
                                                   longint unsigned d, longint unsigned cap);
      longint unsigned q, rem;
      if (s < 0) begin
         a = a >> (-s);
         s = 0;
      end
      if (d == 0) return cap;
      q = a / d;
      rem = a % d;
      if (q > cap) return cap;
      for (int i = 0; i < s; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= d) begin
            rem = rem - d;
            q = q | 1;
         end
         if (q > cap) return cap;
      end
      return q;
   endfunction

   function automatic longint slope_time(int idx, longint ext, longint lvl11);
      longint knob, depth, x;
      knob = longint'(reg_shadow[idx] & 64'h1FFF);
      depth = sext_bits(reg_shadow[2 + idx], 14);
      x = reg_shadow[4 + idx][0] ? lvl11 : ext;
      return knob * 16 + (depth * x) / 1280;
   endfunction

   function automatic longint slope_increment(longint u, bit pp, longint unsigned pm, int pk);
      longint unsigned au, u2, t, sp;
      au = longint'(u < 0 ? -u : u);
      u2 = (au * au) >> 16;
      t = u2 * u2;
      sp = reg_shadow[REG_PERIOD] & 64'hFFFF_FFFF;
      if (pp) return longint'(step_divide(sp * pm, pk + 11, t, 64'd1 << 32));
      return longint'(step_divide(sp, 27, t, 64'd1 << 32));
   endfunction

   function automatic longint clamp_level(longint v);
      longint lim;
      lim = longint'(16) << 27;
      return v > lim ? lim : (v < -lim ? -lim : v);
   endfunction

   function automatic slew_result_type predict_sample(logic [95:0] d, logic [2:0] u);
      slew_result_type r;
      bit sp_on, tr_on, pp, edge_seen, end_f;
      longint sig, sig_acc, trig, both, rx, fx, lvl11, ur, uf, q;
      logic [15:0] pbias;
      int pk;
      longint unsigned pm;
      sp_on = u[0];
      tr_on = u[1];
      pp = u[2];
      sig = sp_on ? longint'($signed(d[15:0])) : 0;
      sig_acc = sig * 65536;
      trig = $signed(d[31:16]);
      pbias = d[47:32] ^ 16'h8000;
      pk = int'(pbias[15:11]) - 16;
      pm = (64'd17145895 * exp2_frac(pbias[10:0])) >> 30;
      both = $signed(d[95:80]);
      rx = longint'($signed(d[63:48])) + both;
      fx = longint'($signed(d[79:64])) + both;
      rx = rx > 20480 ? 20480 : (rx < -20480 ? -20480 : rx);
      fx = fx > 20480 ? 20480 : (fx < -20480 ? -20480 : fx);
      lvl11 = acc_to_volts(level_acc);
      ur = slope_time(0, rx, lvl11);
      uf = slope_time(1, fx, lvl11);
      edge_seen = 0;
      end_f = 1;
      if (tr_on) begin
         if (trig_high) begin
            if (trig <= 0) trig_high = 0;
         end else if (trig >= 2048) begin
            trig_high = 1;
            edge_seen = 1;
         end
      end
      if ((edge_seen || reg_shadow[REG_CYCLE][0]) &&
          (stage == STAGE_IDLE || stage == STAGE_DONE))
         stage = STAGE_RISE;
      if ((sp_on && sig_acc > level_acc) || stage == STAGE_RISE) begin
         if (ur == 0) begin
            level_acc = sig_acc;
            stage = STAGE_FALL;
         end else begin
            level_acc = clamp_level(level_acc + slope_increment(ur, pp, pm, pk));
            end_f = 0;
         end
         if (sp_on && level_acc >= sig_acc) level_acc = sig_acc;
         if (stage == STAGE_RISE && level_acc >= (longint'(8) << 27)) begin
            stage = STAGE_FALL;
            level_acc = longint'(8) << 27;
         end
      end else if ((sp_on && sig_acc < level_acc) || stage == STAGE_FALL) begin
         if (uf == 0) begin
            level_acc = sig_acc;
            stage = STAGE_DONE;
         end else begin
            level_acc = clamp_level(level_acc - slope_increment(uf, pp, pm, pk));
            end_f = 0;
         end
         if (sp_on && level_acc <= sig_acc) level_acc = sig_acc;
         if (stage == STAGE_FALL && level_acc <= 0) begin
            stage = STAGE_DONE;
            level_acc = 0;
         end
      end
      q = acc_to_volts(level_acc);
      r.zero_fill = '0;
      r.level = 16'(sat16(q));
      r.end_flag = end_f;
      r.gate = level_acc > (longint'(5) << 27);
      r.bipolar = 16'(sat16(q - 10240));
      return r;
   endfunction

   function automatic sample_item_type make_sample(int sig, bit sp, int trig, bit tp, int pitch,
                                                   bit pp, int rcv, int fcv, int bcv);
      sample_item_type s;
      s.data = {16'(bcv), 16'(fcv), 16'(rcv), 16'(pitch), 16'(trig), 16'(sig)};
      s.user = {pp, tp, sp};
      return s;
   endfunction

   function automatic int pick_volts(int wide_pct, int span);
      if ($urandom_range(99) < wide_pct) return int'($urandom_range(65535)) - 32768;
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic sample_item_type random_sample();
      int trig;
      case ($urandom_range(4))
         0: trig = 0;
         1: trig = 2048;
         2: trig = int'($urandom_range(20480));
         3: trig = -int'($urandom_range(4096));
         default: trig = pick_volts(100, 0);
      endcase
      return make_sample(pick_volts(25, 20480), $urandom_range(1), trig,
                         $urandom_range(99) < 80, pick_volts(15, 4096),
                         $urandom_range(99) < 30, pick_volts(15, 4096),
                         pick_volts(15, 4096), pick_volts(10, 2048));
   endfunction

   // Request driver and result stall generator.
   always @(negedge clock) begin
      sample_item_type s;
      if (!reset) begin
         if (!req_tvalid || n_taken == n_sent) begin
            if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               s = sample_q.pop_front();
               req_tdata <= s.data;
               req_tuser <= s.user;
               req_tvalid <= 1'b1;
               n_sent++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= $urandom_range(99) >= recv_idle;
      end
   end

   // Prediction on acceptance, result checking and watchdog.
   always @(posedge clock) begin
      slew_result_type got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            n_taken++;
            result_q.push_back(predict_sample(req_tdata, req_tuser));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (result_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = result_q.pop_front();
               if (got.level !== want.level) begin
                  $display("%0t: level_out expected %0d actual %0d", $time, want.level,
                           got.level);
                  errors++;
               end
               if (got.end_flag !== want.end_flag) begin
                  $display("%0t: end_flag expected %0d actual %0d", $time, want.end_flag,
                           got.end_flag);
                  errors++;
               end
               if (got.gate !== want.gate) begin
                  $display("%0t: gate_out expected %0d actual %0d", $time, want.gate,
                           got.gate);
                  errors++;
               end
               if (got.bipolar !== want.bipolar) begin
                  $display("%0t: bipolar_out expected %0d actual %0d", $time, want.bipolar,
                           got.bipolar);
                  errors++;
               end
               if (got.zero_fill !== 6'd0) begin
                  $display("%0t: zero fill expected 0 actual %h", $time, got.zero_fill);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic write_reg(sfg_reg_type idx, longint unsigned value);
      int w;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 5'(int'(idx) * 4);
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      w = (idx <= REG_FALL_KNOB) ? 13 : (idx <= REG_FALL_DEPTH) ? 14 :
          (idx == REG_PERIOD) ? 32 : 1;
      reg_shadow[idx] = value & ((64'd1 << w) - 1);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      wait (sample_q.size() == 0 && !req_tvalid && result_q.size() == 0);
      repeat (120) @(posedge clock);
   endtask

   task automatic random_phase(int count, int s_idle, int r_idle);
      send_idle = s_idle;
      recv_idle = r_idle;
      for (int i = 0; i < count; i++) sample_q.push_back(random_sample());
      drain();
   endtask

   initial begin
      for (int i = 0; i < 8; i++) reg_shadow[i] = 0;
      reg_shadow[REG_PERIOD] = 89478;
      level_acc = 0;
      stage = STAGE_IDLE;
      trig_high = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero slope times with reset registers: the level jumps to the input.
      sample_q.push_back(make_sample(32767, 1, 0, 1, 0, 0, 0, 0, 0));
      sample_q.push_back(make_sample(-32768, 1, 0, 1, 0, 0, 0, 0, 0));
      sample_q.push_back(make_sample(0, 0, 2048, 1, 0, 0, 0, 0, 0));
      sample_q.push_back(make_sample(0, 0, 0, 1, 0, 0, 0, 0, 0));
      sample_q.push_back(make_sample(0, 0, 4096, 0, 0, 0, 0, 0, 0));
      sample_q.push_back(make_sample(0, 0, 2047, 1, 0, 0, 0, 0, 0));
      drain();

      write_reg(REG_RISE_KNOB, 1);
      write_reg(REG_FALL_KNOB, 200);
      write_reg(REG_RISE_DEPTH, 4096);
      write_reg(REG_FALL_DEPTH, 64'hFFFF_F000);
      write_reg(REG_RISE_SELF, 0);
      write_reg(REG_FALL_SELF, 0);
      write_reg(REG_CYCLE, 0);
      write_reg(REG_PERIOD, 89478);
      sample_q.push_back(make_sample(0, 0, -32768, 1, 0, 0, 0, 0, 0));
      sample_q.push_back(make_sample(0, 0, 32767, 1, 0, 0, 0, 0, 0));
      sample_q.push_back(make_sample(0, 0, 32767, 1, 32767, 1, 32767, 32767, 32767));
      sample_q.push_back(make_sample(0, 0, 0, 1, -32768, 1, -32768, -32768, -32768));
      sample_q.push_back(make_sample(0, 0, 2048, 1, 0, 1, 20480, -20480, 0));
      sample_q.push_back(make_sample(20480, 1, 0, 1, 4096, 1, 0, 0, 0));
      sample_q.push_back(make_sample(-20480, 1, 0, 0, 0, 0, 0, 0, 0));
      sample_q.push_back(make_sample(32767, 1, 0, 1, 32767, 1, 0, 0, 0));
      sample_q.push_back(make_sample(-32768, 1, 0, 1, -32768, 1, 0, 0, 0));
      drain();

      // A zero sample period holds the level unless a slope time is zero or its divisor rounds to zero.
      write_reg(REG_PERIOD, 0);
      write_reg(REG_CYCLE, 1);
      write_reg(REG_RISE_KNOB, 100);
      for (int i = 0; i < 4; i++) sample_q.push_back(random_sample());
      drain();

      write_reg(REG_RISE_KNOB, $urandom_range(800, 100));
      write_reg(REG_FALL_KNOB, $urandom_range(800, 100));
      write_reg(REG_RISE_DEPTH, $urandom_range(8192) - 4096);
      write_reg(REG_FALL_DEPTH, $urandom_range(8192) - 4096);
      write_reg(REG_RISE_SELF, $urandom_range(1));
      write_reg(REG_FALL_SELF, $urandom_range(1));
      write_reg(REG_PERIOD, $urandom_range(400000, 1000));
      random_phase(330, 7, 71);

      write_reg(REG_RISE_KNOB, 4096);
      write_reg(REG_FALL_KNOB, 4096);
      write_reg(REG_RISE_DEPTH, 64'hFFFF_F000);
      write_reg(REG_FALL_DEPTH, 4096);
      write_reg(REG_RISE_SELF, 1);
      write_reg(REG_FALL_SELF, 1);
      write_reg(REG_PERIOD, 32'hFFFF_FFFF);
      random_phase(170, 71, 7);

      write_reg(REG_RISE_KNOB, ($urandom() << 13) | $urandom_range(300));
      write_reg(REG_FALL_KNOB, $urandom_range(300));
      write_reg(REG_RISE_DEPTH, $urandom());
      write_reg(REG_FALL_DEPTH, $urandom());
      write_reg(REG_RISE_SELF, 0);
      write_reg(REG_FALL_SELF, 0);
      write_reg(REG_CYCLE, $urandom_range(1));
      write_reg(REG_PERIOD, $urandom());
      random_phase(170, 71, 7);

      write_reg(REG_RISE_KNOB, $urandom_range(400, 20));
      write_reg(REG_FALL_KNOB, $urandom_range(400, 20));
      write_reg(REG_CYCLE, 1);
      write_reg(REG_PERIOD, 89478);
      random_phase(330, 0, 0);

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
